@@ src/ile_pkg.sv @@
// Package for the indexed list engine: operation codes, command flags and
// the transfer payload types. No dependencies.
package ile_pkg;

  localparam int unsigned DefCapacity = 64;
  localparam int unsigned KindW       = 3;
  localparam int unsigned PosW        = 7;
  localparam int unsigned DataW       = 32;

  typedef enum logic [KindW-1:0] {
    KIND_APPEND    = 3'd0,
    KIND_INSERT    = 3'd1,
    KIND_DEL_FIRST = 3'd2,
    KIND_DEL_LAST  = 3'd3,
    KIND_READ      = 3'd4,
    KIND_WRITE     = 3'd5
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COLLECT,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [KindW-1:0]        kind;
    logic [PosW-1:0]         position;
    logic signed [DataW-1:0] new_value;
  } item_t;

  typedef struct packed {
    logic                    ok;
    logic signed [DataW-1:0] read_value;
    logic [PosW-1:0]         count;
    logic signed [DataW-1:0] head_value;
    logic signed [DataW-1:0] tail_value;
  } res_t;

  // Broadcast to every cell of the chain.
  typedef struct packed {
    logic ins;      // cells above the position take the left neighbour
    logic load;     // cell at the position takes the new value
    logic delf;     // every cell takes the right neighbour
    logic collect;  // read and tail lanes step towards cell zero
    logic rd_en;    // read lane picks up the addressed cell
    logic tl_en;    // tail lane picks up the last cell
  } ile_cmd_t;

endpackage

@@ src/ile_cell.sv @@
// One cell of the list chain: holds one entry and one stage of the read and
// tail lanes. Depends on ile_pkg.
module ile_cell import ile_pkg::*; #(
  parameter int unsigned IDX = 0,
  parameter int unsigned IW  = 6
) (
  input  logic                    clk_i,
  input  ile_cmd_t                cmd_i,
  input  logic [IW-1:0]           pos_i,
  input  logic [IW-1:0]           rsel_i,
  input  logic [IW-1:0]           tsel_i,
  input  logic signed [DataW-1:0] new_value_i,
  input  logic signed [DataW-1:0] left_i,
  input  logic signed [DataW-1:0] right_i,
  input  logic signed [DataW-1:0] rd_right_i,
  input  logic signed [DataW-1:0] tl_right_i,
  output logic signed [DataW-1:0] val_o,
  output logic signed [DataW-1:0] rd_o,
  output logic signed [DataW-1:0] tl_o
);

  localparam logic [IW-1:0] MyIdx = IW'(IDX);

  logic signed [DataW-1:0] val_q, val_d, rd_q, rd_d, tl_q, tl_d;

  always_comb begin
    val_d = val_q;
    if (cmd_i.ins && (MyIdx > pos_i)) begin
      val_d = left_i;
    end else if (cmd_i.load && (MyIdx == pos_i)) begin
      val_d = new_value_i;
    end else if (cmd_i.delf) begin
      val_d = right_i;
    end
  end

  always_comb begin
    rd_d = rd_q;
    tl_d = tl_q;
    if (cmd_i.collect) begin
      rd_d = (cmd_i.rd_en && (MyIdx == rsel_i)) ? val_q : rd_right_i;
      tl_d = (cmd_i.tl_en && (MyIdx == tsel_i)) ? val_q : tl_right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    rd_q  <= rd_d;
    tl_q  <= tl_d;
  end

  assign val_o = val_q;
  assign rd_o  = rd_q;
  assign tl_o  = tl_q;

endmodule

@@ src/ile_ctrl.sv @@
// Sequencer of the list engine: checks each operation, keeps the entry count
// and drives the cell chain through its collect pass. Depends on ile_pkg.
module ile_ctrl import ile_pkg::*; #(
  parameter int unsigned CAPACITY = DefCapacity,
  parameter int unsigned IW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
  parameter int unsigned CW       = $clog2(CAPACITY + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  input  item_t         item_i,
  output logic          busy,
  output logic          done_o,
  output logic          ok_o,
  output logic [CW-1:0] count_o,
  output ile_cmd_t      cmd_o,
  output logic [IW-1:0] pos_o,
  output logic [IW-1:0] rsel_o,
  output logic [IW-1:0] tsel_o
);

  localparam int unsigned WW = (CW > PosW) ? CW : PosW;
  localparam logic [CW-1:0] CapCnt  = CW'(CAPACITY);
  localparam logic [IW-1:0] LastIdx = IW'(CAPACITY - 1);

  state_e        state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [IW-1:0] step_q, step_d;
  logic [IW-1:0] rsel_q, rsel_d, tsel_q, tsel_d;
  logic          rd_en_q, rd_en_d, tl_en_q, tl_en_d, ok_q, ok_d;

  logic [WW-1:0] pos_w, cnt_w;
  logic          full, empty, accept;

  assign pos_w  = WW'(item_i.position);
  assign cnt_w  = WW'(cnt_q);
  assign full   = (cnt_q == CapCnt);
  assign empty  = (cnt_q == '0);
  assign accept = start && (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    step_d  = step_q;
    rsel_d  = rsel_q;
    tsel_d  = tsel_q;
    rd_en_d = rd_en_q;
    tl_en_d = tl_en_q;
    ok_d    = ok_q;
    cmd_o   = '0;
    pos_o   = IW'(pos_w);
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          ok_d    = 1'b0;
          rd_en_d = 1'b0;
          rsel_d  = IW'(pos_w);
          case (kind_e'(item_i.kind))
            KIND_APPEND: begin
              if (!full) begin
                ok_d       = 1'b1;
                cmd_o.ins  = 1'b1;
                cmd_o.load = 1'b1;
                pos_o      = IW'(cnt_w);
                cnt_d      = cnt_q + 1'b1;
              end
            end
            KIND_INSERT: begin
              if (!full && (pos_w <= cnt_w)) begin
                ok_d       = 1'b1;
                cmd_o.ins  = 1'b1;
                cmd_o.load = 1'b1;
                cnt_d      = cnt_q + 1'b1;
              end
            end
            KIND_DEL_FIRST: begin
              if (!empty) begin
                ok_d       = 1'b1;
                cmd_o.delf = 1'b1;
                cnt_d      = cnt_q - 1'b1;
              end
            end
            KIND_DEL_LAST: begin
              if (!empty) begin
                ok_d  = 1'b1;
                cnt_d = cnt_q - 1'b1;
              end
            end
            KIND_READ: begin
              if (pos_w < cnt_w) begin
                ok_d    = 1'b1;
                rd_en_d = 1'b1;
              end
            end
            KIND_WRITE: begin
              if (pos_w < cnt_w) begin
                ok_d       = 1'b1;
                cmd_o.load = 1'b1;
              end
            end
            default: begin
            end
          endcase
          tl_en_d = (cnt_d != '0);
          tsel_d  = IW'(cnt_d - 1'b1);
          step_d  = '0;
          state_d = ST_COLLECT;
        end
      end
      ST_COLLECT: begin
        cmd_o.collect = 1'b1;
        cmd_o.rd_en   = rd_en_q;
        cmd_o.tl_en   = tl_en_q;
        step_d        = step_q + 1'b1;
        if (step_q == LastIdx) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      step_q  <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rsel_q  <= rsel_d;
    tsel_q  <= tsel_d;
    rd_en_q <= rd_en_d;
    tl_en_q <= tl_en_d;
    ok_q    <= ok_d;
  end

  assign busy    = (state_q != ST_IDLE);
  assign done_o  = (state_q == ST_DONE);
  assign ok_o    = ok_q;
  assign count_o = cnt_q;
  assign rsel_o  = rsel_q;
  assign tsel_o  = tsel_q;

endmodule

@@ src/indexed_list_engine.sv @@
// Indexed list engine: a bounded ordered list of signed 32-bit entries held
// in a chain of cells. Depends on ile_pkg, ile_ctrl and ile_cell.
//
// Usage:
//   An operation transfers in when start is high and busy is low; item_i
//   carries kind, position and new_value. Append, insert, remove first,
//   remove last, read and write are supported; a rejected operation leaves
//   the list unchanged and reports ok low.
//   The list is updated in the cycle of the transfer: every cell shifts or
//   loads in parallel. The read value and the tail value then travel down
//   the read and tail lanes, one cell per cycle, towards cell zero.
//   The result sits on res_o for exactly one cycle with done_o high, once
//   the lanes have reached cell zero. busy stays high until the result has
//   gone, so a new operation is not taken before the last one is through.
//   The receiver cannot stall; the result must be taken when done_o is high.
//   Reset empties the list; entry contents are not cleared and are never
//   read before they are written.
module indexed_list_engine import ile_pkg::*; #(
  parameter int unsigned CAPACITY = DefCapacity
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start,
  input  item_t item_i,
  output logic  busy,
  output logic  done_o,
  output res_t  res_o
);

  localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  ile_cmd_t      cmd;
  logic [IW-1:0] pos, rsel, tsel;
  logic [CW-1:0] count;
  logic          ok;

  logic signed [DataW-1:0] val [CAPACITY];
  logic signed [DataW-1:0] rd  [CAPACITY];
  logic signed [DataW-1:0] tl  [CAPACITY];

  ile_ctrl #(
    .CAPACITY (CAPACITY),
    .IW       (IW),
    .CW       (CW)
  ) u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .item_i  (item_i),
    .busy    (busy),
    .done_o  (done_o),
    .ok_o    (ok),
    .count_o (count),
    .cmd_o   (cmd),
    .pos_o   (pos),
    .rsel_o  (rsel),
    .tsel_o  (tsel)
  );

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [DataW-1:0] left, right, rd_right, tl_right;
    if (i == 0) begin : g_first
      assign left = '0;
    end else begin : g_mid
      assign left = val[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right    = '0;
      assign rd_right = '0;
      assign tl_right = '0;
    end else begin : g_inner
      assign right    = val[i+1];
      assign rd_right = rd[i+1];
      assign tl_right = tl[i+1];
    end

    ile_cell #(
      .IDX (i),
      .IW  (IW)
    ) u_cell (
      .clk_i       (clk_i),
      .cmd_i       (cmd),
      .pos_i       (pos),
      .rsel_i      (rsel),
      .tsel_i      (tsel),
      .new_value_i (item_i.new_value),
      .left_i      (left),
      .right_i     (right),
      .rd_right_i  (rd_right),
      .tl_right_i  (tl_right),
      .val_o       (val[i]),
      .rd_o        (rd[i]),
      .tl_o        (tl[i])
    );
  end

  always_comb begin
    res_o            = '0;
    res_o.ok         = ok;
    res_o.read_value = rd[0];
    res_o.count      = PosW'(count);
    res_o.head_value = (count != '0) ? val[0] : '0;
    res_o.tail_value = tl[0];
  end

endmodule
